// File: rtl/fida_pkg.sv
// Package for the flow id allocator: request codes, payload structs,
// controller/datapath command and status types, FSM states.
// No dependencies.
package fida_pkg;

    localparam int ID_SLOTS = 1024;
    localparam int ID_W     = 10;
    localparam int TAG_W    = 32;
    localparam int CNT_W    = 10;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_SET   = 2'd2,
        REQ_GET   = 2'd3
    } req_e;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC,
        ST_UNLINK,
        ST_APPEND,
        ST_RESP
    } state_e;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] flow_id;
        logic [TAG_W-1:0] tag_in;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0]  alloc_id;
        logic [TAG_W-1:0] tag_out;
        logic [CNT_W-1:0] used_count;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic init_step;
        logic cap;
        logic alloc;
        logic unlink;
        logic append;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic init_last;
        logic out_busy;
    } stat_t;

    // id 0 is reserved, ids at or above the slot count do not exist
    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return (id != '0) && (32'(id) < ID_SLOTS);
    endfunction

endpackage

// File: rtl/fida_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data and read enable. No dependencies.
module fida_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fida_ctrl.sv
// Sequencing FSM for the id allocator: clearing pass, request dispatch,
// list update steps and result hand-off. Depends on fida_pkg.
module fida_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  fida_pkg::in_t  s_data,
    output logic           s_ready,
    input  fida_pkg::stat_t stat,
    output fida_pkg::cmd_t cmd
);

    fida_pkg::state_e state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fida_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            fida_pkg::ST_INIT: begin
                cmd.init_step = 1'b1;
                if (stat.init_last) begin
                    state_next = fida_pkg::ST_IDLE;
                end
            end
            fida_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap = 1'b1;
                    unique case (s_data.req_type)
                        fida_pkg::REQ_ALLOC: state_next = fida_pkg::ST_ALLOC;
                        fida_pkg::REQ_FREE: begin
                            if (fida_pkg::id_ok(s_data.flow_id)) begin
                                state_next = fida_pkg::ST_UNLINK;
                            end else begin
                                state_next = fida_pkg::ST_RESP;
                            end
                        end
                        default: state_next = fida_pkg::ST_RESP;
                    endcase
                end
            end
            fida_pkg::ST_ALLOC: begin
                cmd.alloc  = 1'b1;
                state_next = fida_pkg::ST_RESP;
            end
            fida_pkg::ST_UNLINK: begin
                cmd.unlink = 1'b1;
                state_next = fida_pkg::ST_APPEND;
            end
            fida_pkg::ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = fida_pkg::ST_RESP;
            end
            fida_pkg::ST_RESP: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = fida_pkg::ST_IDLE;
                end
            end
            default: state_next = fida_pkg::ST_INIT;
        endcase
    end

endmodule

// File: rtl/fida_dp.sv
// Datapath: link, free-flag and tag memories, list head/tail/count
// registers and the output register. Depends on fida_pkg and fida_ram.
module fida_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  fida_pkg::cmd_t  cmd,
    input  fida_pkg::in_t   s_data,
    input  logic            m_ready,
    output fida_pkg::stat_t stat,
    output logic            m_valid,
    output fida_pkg::out_t  m_data
);

    localparam int IW = fida_pkg::ID_W;
    localparam int TW = fida_pkg::TAG_W;
    localparam int CW = fida_pkg::CNT_W;

    // list state
    logic [IW-1:0] head_reg, tail_reg;
    logic          empty_reg;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] init_idx_reg;
    logic          out_valid_reg;

    // captured transaction
    logic [1:0]     req_reg;
    logic [IW-1:0]  id_reg;
    logic [IW-1:0]  granted_reg;
    fida_pkg::out_t out_reg;

    // RAM ports
    logic          nxt_we, prv_we, fre_we, tag_we;
    logic [IW-1:0] nxt_wa, prv_wa, fre_wa, tag_wa;
    logic [IW-1:0] nxt_wd, prv_wd;
    logic [0:0]    fre_wd;
    logic [TW-1:0] tag_wd;
    logic [IW-1:0] nxt_ra;
    logic [IW-1:0] nxt_rd, prv_rd;
    logic [0:0]    fre_rd;
    logic [TW-1:0] tag_rd;

    logic [IW-1:0] init_nxt, init_prv;
    logic          mid_unlink;
    logic          cap_id_ok;

    // reset image: ascending chain 1..N-1
    assign init_nxt = (init_idx_reg != '0 && init_idx_reg != IW'(fida_pkg::ID_SLOTS - 1))
                      ? init_idx_reg + IW'(1) : '0;
    assign init_prv = (init_idx_reg > IW'(1)) ? init_idx_reg - IW'(1) : '0;

    assign cap_id_ok  = fida_pkg::id_ok(s_data.flow_id);
    assign mid_unlink = fre_rd[0] && (head_reg != id_reg) && (tail_reg != id_reg);
    assign nxt_ra     = (s_data.req_type == fida_pkg::REQ_ALLOC) ? head_reg : s_data.flow_id;

    always_comb begin
        nxt_we = 1'b0;
        nxt_wa = init_idx_reg;
        nxt_wd = init_nxt;
        if (cmd.init_step) begin
            nxt_we = 1'b1;
        end else if (cmd.unlink && mid_unlink) begin
            nxt_we = 1'b1;
            nxt_wa = prv_rd;
            nxt_wd = nxt_rd;
        end else if (cmd.append && !empty_reg) begin
            nxt_we = 1'b1;
            nxt_wa = tail_reg;
            nxt_wd = id_reg;
        end
    end

    always_comb begin
        prv_we = 1'b0;
        prv_wa = init_idx_reg;
        prv_wd = init_prv;
        if (cmd.init_step) begin
            prv_we = 1'b1;
        end else if (cmd.unlink && mid_unlink) begin
            prv_we = 1'b1;
            prv_wa = nxt_rd;
            prv_wd = prv_rd;
        end else if (cmd.append && !empty_reg) begin
            prv_we = 1'b1;
            prv_wa = id_reg;
            prv_wd = tail_reg;
        end
    end

    always_comb begin
        fre_we = 1'b0;
        fre_wa = init_idx_reg;
        fre_wd = 1'(init_idx_reg != '0);
        if (cmd.init_step) begin
            fre_we = 1'b1;
        end else if (cmd.alloc && !empty_reg) begin
            fre_we = 1'b1;
            fre_wa = head_reg;
            fre_wd = 1'b0;
        end else if (cmd.append) begin
            fre_we = 1'b1;
            fre_wa = id_reg;
            fre_wd = 1'b1;
        end
    end

    always_comb begin
        tag_we = 1'b0;
        tag_wa = init_idx_reg;
        tag_wd = '0;
        if (cmd.init_step) begin
            tag_we = 1'b1;
        end else if (cmd.cap && cap_id_ok &&
                     (s_data.req_type == fida_pkg::REQ_FREE ||
                      s_data.req_type == fida_pkg::REQ_SET)) begin
            tag_we = 1'b1;
            tag_wa = s_data.flow_id;
            tag_wd = (s_data.req_type == fida_pkg::REQ_SET) ? s_data.tag_in : '0;
        end
    end

    fida_ram #(.WIDTH(IW), .DEPTH(fida_pkg::ID_SLOTS)) u_nxt_ram (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
        .re(cmd.cap), .raddr(nxt_ra), .rdata(nxt_rd)
    );

    fida_ram #(.WIDTH(IW), .DEPTH(fida_pkg::ID_SLOTS)) u_prv_ram (
        .aclk(aclk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
        .re(cmd.cap), .raddr(s_data.flow_id), .rdata(prv_rd)
    );

    fida_ram #(.WIDTH(1), .DEPTH(fida_pkg::ID_SLOTS)) u_fre_ram (
        .aclk(aclk), .we(fre_we), .waddr(fre_wa), .wdata(fre_wd),
        .re(cmd.cap), .raddr(s_data.flow_id), .rdata(fre_rd)
    );

    fida_ram #(.WIDTH(TW), .DEPTH(fida_pkg::ID_SLOTS)) u_tag_ram (
        .aclk(aclk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
        .re(cmd.cap), .raddr(s_data.flow_id), .rdata(tag_rd)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= IW'(1);
            tail_reg      <= IW'(fida_pkg::ID_SLOTS - 1);
            empty_reg     <= 1'b0;
            count_reg     <= '0;
            init_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.init_step) begin
                init_idx_reg <= init_idx_reg + IW'(1);
            end
            // pop the head
            if (cmd.alloc && !empty_reg) begin
                if (head_reg == tail_reg) begin
                    empty_reg <= 1'b1;
                end else begin
                    head_reg <= nxt_rd;
                end
                count_reg <= count_reg + CW'(1);
            end
            // take the freed id out of the list if it is on it
            if (cmd.unlink && fre_rd[0]) begin
                if (head_reg == id_reg && tail_reg == id_reg) begin
                    empty_reg <= 1'b1;
                end else if (head_reg == id_reg) begin
                    head_reg <= nxt_rd;
                end else if (tail_reg == id_reg) begin
                    tail_reg <= prv_rd;
                end
            end
            // push at the tail
            if (cmd.append) begin
                if (empty_reg) begin
                    head_reg  <= id_reg;
                    empty_reg <= 1'b0;
                end
                tail_reg <= id_reg;
                if (count_reg != '0) begin
                    count_reg <= count_reg - CW'(1);
                end
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            req_reg     <= s_data.req_type;
            id_reg      <= s_data.flow_id;
            granted_reg <= '0;
        end
        if (cmd.alloc && !empty_reg) begin
            granted_reg <= head_reg;
        end
        if (cmd.load_out) begin
            out_reg.alloc_id   <= granted_reg;
            out_reg.tag_out    <= (req_reg == fida_pkg::REQ_GET && fida_pkg::id_ok(id_reg))
                                  ? tag_rd : '0;
            out_reg.used_count <= count_reg;
        end
    end

    assign stat.init_last = (init_idx_reg == IW'(fida_pkg::ID_SLOTS - 1));
    assign stat.out_busy  = out_valid_reg && !m_ready;
    assign m_valid        = out_valid_reg;
    assign m_data         = out_reg;

endmodule

// File: rtl/fifo_id_allocator_with_tags_top.sv
// Accept to result: set/get tag and ignored ids go straight to the result state,
// allocate passes through ALLOC, free of a valid id through UNLINK and APPEND. One
// transaction in flight: the next is accepted the cycle after a result loads.
// Result sits in an output register, so the next request is accepted while it waits.
// Reset (aresetn low, synchronous) starts a clearing pass over all 1024 slots that
// writes the free-list chain, free flags and zero tags; s_ready stays low until it is done.
module fifo_id_allocator_with_tags_top (
    input  logic           aclk,
    input  logic           aresetn,
    // request channel
    input  logic           s_valid,
    output logic           s_ready,
    input  fida_pkg::in_t  s_data,
    // result channel
    output logic           m_valid,
    input  logic           m_ready,
    output fida_pkg::out_t m_data
);

    // Controller walks each transaction through its list update steps:
    //   allocate: read next link of head -> pop head
    //   free:     read links/flag of valid id -> unlink if listed -> append at tail
    //   set/get:  tag RAM write or read done at accept
    fida_pkg::cmd_t  cmd;
    fida_pkg::stat_t stat;

    fida_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_data  (s_data),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath owns the four RAMs (next, prev, free flag, tag), the list
    // head/tail/empty/count registers and the result register.
    fida_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_ready (m_ready),
        .stat    (stat),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

// File: rtl/fida_chk.sv
// Port-level checker for the id allocator, bound to the top level.
// Depends on fida_pkg.
module fida_chk (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input fida_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input fida_pkg::out_t m_data
);

    // no result may be pending right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // one request at a time: accept closes the input for the next cycle
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted back to back");

    // a granted id never comes with a tag readout
    a_grant_no_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.alloc_id != '0 |-> m_data.tag_out == '0)
        else $error("grant and tag readout in one result");

endmodule

bind fifo_id_allocator_with_tags_top fida_chk u_fida_chk (.*);
